>>> sv/hte_pkg.sv
package hte_pkg;

  localparam int MAX_CODE_LEN = 16;
  localparam int VAL_W        = 16;
  localparam int LEN_W        = 5;
  localparam int SYM_W        = 8;
  localparam int LEN_LIMIT    = (MAX_CODE_LEN < VAL_W) ? MAX_CODE_LEN : VAL_W;
  localparam int TBL_DEPTH    = 1 << SYM_W;
  localparam int QDEPTH       = 4;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int QCNT_W       = QPTR_W + 1;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [LEN_W-1:0] length;
  } entry_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_t;

  typedef struct packed {
    logic [1:0] cnt;
    byte_t      b0;
    byte_t      b1;
  } push_t;

endpackage

>>> sv/huffman_table_encoder_packer.sv
// an accepted item is held in stage 1 with its registered table entry; its output words are
//   written into the output queue when stage 1 is taken and are valid on the port from then on
// throughput: one item per cycle while the 4-word output queue has two free slots;
//   items that emit two words each are held back by the 1-word output port
// table lookup is one synchronous memory read, registered, per item
// reset (synchronous, active low) clears the table valid bits, the bit accumulator
//   and the output queue directly; no clearing pass
module huffman_table_encoder_packer
  import hte_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_op,
  input  logic [SYM_W-1:0] in_symbol,
  input  logic [VAL_W-1:0] in_code_value,
  input  logic [LEN_W-1:0] in_code_length,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             out_last
);

  logic       s1_vld_r, s1_vld_nxt;
  logic [1:0] s1_op_r;
  logic       s1_take;
  logic       in_acc;
  logic       room;
  entry_t     entry;
  push_t      push;
  byte_t      head;

  assign s1_take  = s1_vld_r && room;
  assign in_stall = s1_vld_r && !room;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_acc) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_take) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r <= in_op;
    end
  end

  hte_table u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (in_acc && (in_op == OP_LOAD)),
    .rd_en     (in_acc),
    .addr      (in_symbol),
    .wr_value  (in_code_value),
    .wr_length (in_code_length),
    .rd_entry  (entry)
  );

  hte_packer u_packer (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (s1_take),
    .op    (s1_op_r),
    .entry (entry),
    .push  (push)
  );

  hte_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (out_valid && !out_stall),
    .room  (room),
    .vld   (out_valid),
    .head  (head)
  );

  assign out_byte = head.data;
  assign out_last = head.last;

endmodule

>>> sv/hte_table.sv
module hte_table
  import hte_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic             rd_en,
  input  logic [SYM_W-1:0] addr,
  input  logic [VAL_W-1:0] wr_value,
  input  logic [LEN_W-1:0] wr_length,
  output entry_t           rd_entry
);

  entry_t               mem [TBL_DEPTH];
  logic [TBL_DEPTH-1:0] valid_r;
  entry_t               rd_data_r;
  logic                 rd_vld_r;
  logic [LEN_W-1:0]     len_c;
  logic [VAL_W:0]       mask;
  entry_t               wr_entry;

  // clamp the length and drop value bits above it
  always_comb begin
    len_c = (wr_length > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT) : wr_length;
    mask  = ((VAL_W+1)'(1) << len_c) - (VAL_W+1)'(1);
    wr_entry.length = len_c;
    wr_entry.value  = wr_value & mask[VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[addr];
      end
    end
  end

  // an entry never loaded since reset reads as an empty code
  assign rd_entry = rd_vld_r ? rd_data_r : '0;

endmodule

>>> sv/hte_packer.sv
module hte_packer
  import hte_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [1:0] op,
  input  entry_t     entry,
  output push_t      push
);

  logic [6:0]       pbits_r, pbits_nxt;
  logic [2:0]       pcount_r, pcount_nxt;
  logic [22:0]      acc;
  logic [LEN_W-1:0] total;
  logic [LEN_W-1:0] sh0, sh1;
  logic [22:0]      byte0_w, byte1_w;
  logic [7:0]       rmask;
  logic [14:0]      fl_w;
  logic [1:0]       nbytes;

  always_comb begin
    acc     = (23'({pbits_r}) << entry.length) | 23'(entry.value);
    total   = LEN_W'(pcount_r) + entry.length;
    nbytes  = total[4:3];
    sh0     = total - LEN_W'(8);
    sh1     = total - LEN_W'(16);
    byte0_w = acc >> sh0;
    byte1_w = acc >> sh1;
    rmask   = (8'd1 << total[2:0]) - 8'd1;
    fl_w    = {8'b0, pbits_r} << (4'd8 - {1'b0, pcount_r});
  end

  always_comb begin
    push       = '0;
    pbits_nxt  = pbits_r;
    pcount_nxt = pcount_r;
    if (take) begin
      unique case (op)
        OP_ENCODE: begin
          if (entry.length != '0) begin
            push.cnt       = nbytes;
            push.b0.data   = byte0_w[7:0];
            push.b0.last   = (nbytes == 2'd1);
            push.b1.data   = byte1_w[7:0];
            push.b1.last   = 1'b1;
            pcount_nxt     = total[2:0];
            pbits_nxt      = acc[6:0] & rmask[6:0];
          end
        end
        OP_FLUSH: begin
          if (pcount_r != '0) begin
            push.cnt     = 2'd1;
            push.b0.data = fl_w[7:0];
            push.b0.last = 1'b1;
            pcount_nxt   = '0;
            pbits_nxt    = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pbits_r  <= '0;
      pcount_r <= '0;
    end else begin
      pbits_r  <= pbits_nxt;
      pcount_r <= pcount_nxt;
    end
  end

endmodule

>>> sv/hte_outq.sv
module hte_outq
  import hte_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  input  logic  pop,
  output logic  room,
  output logic  vld,
  output byte_t head
);

  byte_t             q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic [QPTR_W-1:0] wr_ptr_p1;

  assign wr_ptr_p1 = wr_ptr_r + QPTR_W'(1);
  // two free slots so a full encode result always fits
  assign room = (count_r <= QCNT_W'(QDEPTH - 2));
  assign vld  = (count_r != '0);
  assign head = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop);
    count_nxt  = count_r + QCNT_W'(push.cnt) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      q_r[wr_ptr_r] <= push.b0;
    end
    if (push.cnt == 2'd2) begin
      q_r[wr_ptr_p1] <= push.b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> sv/hte_checker.sv
module hte_checker
  import hte_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [7:0]       out_byte,
  input logic             out_last
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled output word changed");

  // both words of an item are queued together, so a non-final word is never followed by a gap
  a_pair_together: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid)
    else $error("gap inside a multi-word run");

  // output starts only from an item that was accepted, then passed stage 1 into the queue
  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("output word without a matching input");

  // input stall only appears behind a freshly taken item
  a_stall_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(in_valid))
    else $error("input stall without a held item");

endmodule

bind huffman_table_encoder_packer hte_checker u_hte_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_byte  (out_byte),
  .out_last  (out_last)
);
